// ===== design/u16u8_pkg.sv =====
// types, constants and the utf-8 encoder shared by the transcoder files
package u16u8_pkg;

   localparam int QueueDepthDefault = 2;

   localparam logic [15:0] HighFirst = 16'hD800;
   localparam logic [15:0] HighLast  = 16'hDBFF;
   localparam logic [15:0] LowFirst  = 16'hDC00;
   localparam logic [15:0] LowLast   = 16'hDFFF;

   localparam logic [20:0] SuppBase = 21'h10000;
   localparam logic [20:0] Limit1   = 21'h00080;
   localparam logic [20:0] Limit2   = 21'h00800;
   localparam logic [20:0] Limit3   = 21'h10000;

   localparam logic [7:0] Lead2 = 8'hC0;
   localparam logic [7:0] Lead3 = 8'hE0;
   localparam logic [7:0] Lead4 = 8'hF0;
   localparam logic [7:0] Cont  = 8'h80;

   localparam int SeqBytes = 4;
   localparam int JobBytes = 6;

   typedef struct packed {
      logic [SeqBytes-1:0][7:0] seq;
      logic [2:0]               len;
   } utf8_seq_type;

   typedef struct packed {
      logic [JobBytes-1:0][7:0] seq;
      logic [2:0]               len;
      logic                     string_last;
   } job_type;

   function automatic utf8_seq_type encode(input logic [20:0] cp);
      utf8_seq_type r;
      r = '0;
      if (cp < Limit1) begin
         r.seq[0] = cp[7:0];
         r.len    = 3'd1;
      end else if (cp < Limit2) begin
         r.seq[0] = Lead2 | {3'b000, cp[10:6]};
         r.seq[1] = Cont | {2'b00, cp[5:0]};
         r.len    = 3'd2;
      end else if (cp < Limit3) begin
         r.seq[0] = Lead3 | {4'b0000, cp[15:12]};
         r.seq[1] = Cont | {2'b00, cp[11:6]};
         r.seq[2] = Cont | {2'b00, cp[5:0]};
         r.len    = 3'd3;
      end else begin
         r.seq[0] = Lead4 | {5'b00000, cp[20:18]};
         r.seq[1] = Cont | {2'b00, cp[17:12]};
         r.seq[2] = Cont | {2'b00, cp[11:6]};
         r.seq[3] = Cont | {2'b00, cp[5:0]};
         r.len    = 3'd4;
      end
      return r;
   endfunction

endpackage

// ===== design/u16u8_chan_if.sv =====
// valid/ready channel interfaces for code units and utf-8 bytes
interface u16u8_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        string_last;

   modport source (output valid, output code_unit, output string_last, input ready);
   modport sink   (input valid, input code_unit, input string_last, output ready);
endinterface

interface u16u8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_end;

   modport source (output valid, output out_byte, output run_last, output string_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input string_end,
                   output ready);
endinterface

// ===== design/utf16_to_utf8_transcoder_top.sv =====
// utf-16 to utf-8 transcoder top level
// a unit's job is written to the queue, then loaded into the byte sender before its first byte goes out
// throughput: one byte per cycle at the output while the sink is ready; a unit causes
//   1 to 6 bytes, or none when it only holds a high surrogate
// the byte sender in the back end sets the rate; the front takes a unit per cycle while the queue is not full
// reset: synchronous, clears the pending surrogate, the queue and the byte sender
module utf16_to_utf8_transcoder_top #(
   parameter int QueueDepth = u16u8_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   u16u8_req_if.sink   req_chan,
   u16u8_rsp_if.source rsp_chan
);

   logic               push_valid;
   u16u8_pkg::job_type push_job;
   logic               q_full;
   logic               pop;
   logic               head_valid;
   u16u8_pkg::job_type head_job;

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   u16u8_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== design/u16u8_front.sv =====
// front end: takes code units, pairs surrogates and builds byte jobs
module u16u8_front (
   input  logic                 clock,
   input  logic                 reset,
   u16u8_req_if.sink            req_chan,
   input  logic                 q_full,
   output logic                 push_valid,
   output u16u8_pkg::job_type   push_job
);

   logic [9:0] held_high_ff, held_high_in;
   logic       held_valid_ff, held_valid_in;
   logic       accept;
   logic       is_high, is_low;
   logic [20:0] supp_cp;
   u16u8_pkg::utf8_seq_type pend_seq, unit_seq, supp_seq;
   u16u8_pkg::job_type      job;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && req_chan.ready;

   assign is_high = req_chan.code_unit inside {[u16u8_pkg::HighFirst:u16u8_pkg::HighLast]};
   assign is_low  = req_chan.code_unit inside {[u16u8_pkg::LowFirst:u16u8_pkg::LowLast]};

   assign supp_cp  = u16u8_pkg::SuppBase + {1'b0, held_high_ff, req_chan.code_unit[9:0]};
   assign supp_seq = u16u8_pkg::encode(supp_cp);
   assign pend_seq = u16u8_pkg::encode({5'b0, u16u8_pkg::HighFirst[15:10], held_high_ff});
   assign unit_seq = u16u8_pkg::encode({5'b0, req_chan.code_unit});

   always_comb begin
      job = '0;
      job.string_last = req_chan.string_last;
      held_high_in  = held_high_ff;
      held_valid_in = held_valid_ff;
      if (held_valid_ff && is_low) begin
         job.seq[3:0]  = supp_seq.seq;
         job.len       = supp_seq.len;
         held_valid_in = 1'b0;
         held_high_in  = '0;
      end else begin
         held_valid_in = is_high && !req_chan.string_last;
         held_high_in  = is_high && !req_chan.string_last ? req_chan.code_unit[9:0] : '0;
         if (held_valid_ff) begin
            // pending unit goes first, the new unit's bytes follow it unless it is held as a new high surrogate
            job.seq[2:0] = pend_seq.seq[2:0];
            job.len      = 3'd3;
            if (!held_valid_in) begin
               job.seq[5:3] = unit_seq.seq[2:0];
               job.len      = 3'd3 + unit_seq.len;
            end
         end else if (!held_valid_in) begin
            job.seq[3:0] = unit_seq.seq;
            job.len      = unit_seq.len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_high_ff  <= '0;
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         held_high_ff  <= held_high_in;
         held_valid_ff <= held_valid_in;
      end
   end

   assign push_valid = accept && (job.len != 3'd0);
   assign push_job   = job;

endmodule

// ===== design/u16u8_queue.sv =====
// short job queue between front and back ends
module u16u8_queue #(
   parameter int Depth = u16u8_pkg::QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  u16u8_pkg::job_type   push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output u16u8_pkg::job_type   head_job
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   u16u8_pkg::job_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = count_ff == CntW'(Depth);
   assign head_valid = count_ff != '0;
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== design/u16u8_back.sv =====
// back end: sends the utf-8 bytes of the current job one per handshake
module u16u8_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  u16u8_pkg::job_type   head_job,
   output logic                 pop,
   u16u8_rsp_if.source          rsp_chan
);

   u16u8_pkg::job_type cur_ff, cur_in;
   logic               busy_ff, busy_in;
   logic [2:0]         idx_ff, idx_in;
   logic               final_byte;
   logic               taken;

   assign final_byte = idx_ff == (cur_ff.len - 3'd1);
   assign taken      = busy_ff && rsp_chan.ready;
   assign pop        = head_valid && (!busy_ff || (taken && final_byte));

   assign rsp_chan.valid      = busy_ff;
   assign rsp_chan.out_byte   = cur_ff.seq[idx_ff];
   assign rsp_chan.run_last   = final_byte;
   assign rsp_chan.string_end = final_byte && cur_ff.string_last;

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         cur_in  = head_job;
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (taken) begin
         if (final_byte) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule
